// File: hw/rtl/vppu_pkg.sv
// shared types and constants for the video register and raster timing core
`default_nettype none
package vppu_pkg;
    localparam int VideoMemDepthDef   = 8192;
    localparam int SpritesPerLineDef  = 8;
    localparam int SpriteMemDepth     = 256;

    localparam logic [9:0] DotsPerLine   = 10'd341;
    localparam logic [9:0] LinesPerFrame = 10'd262;
    localparam logic [8:0] LinePreRender = 9'd261;
    localparam logic [8:0] LineVblank    = 9'd241;
    localparam logic [8:0] LineVisEnd    = 9'd240;
    localparam logic [8:0] DotEvalFirst  = 9'd65;
    localparam logic [8:0] DotEvalLast   = 9'd256;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_SPR   = 2'd3
    } t_action;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // work handed from the front stage to the status stage
    typedef struct packed {
        t_action    act;
        logic [2:0] rg;
        logic [7:0] wdata;
        logic       vbl_clr;
        logic       vbl_set;
        logic       cnt_clr;
        logic       eval;
        logic [7:0] ln;
        logic       ctrl_nmi;
        logic [8:0] line;
        logic [8:0] dot;
    } t_req;
endpackage
`default_nettype wire

// File: hw/rtl/video_ppu_registers_and_timing_core.sv
// top level of the video register and raster timing core
// result path: front stage register with ram read, then status stage register
// throughput: one transaction per cycle while not stalled, single-port rams
// reset: synchronous active low; then a sweep over all VIDEO_MEM_DEPTH addresses
// zeroes video and sprite memory, input ready stays low meanwhile
`default_nettype none
module video_ppu_registers_and_timing_core #(
    parameter int VIDEO_MEM_DEPTH  = vppu_pkg::VideoMemDepthDef,
    parameter int SPRITES_PER_LINE = vppu_pkg::SpritesPerLineDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // address[7:0], write_data[15:8]
    input  wire logic [1:0]  i_s_tuser,  // action[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata   // read_data[7:0], nmi_request[8],
                                         // line_number[17:9], dot_number[26:18],
                                         // in_vblank[27], zero[31:28]
);
    import vppu_pkg::*;
    localparam int AW = $clog2(VIDEO_MEM_DEPTH);

    t_req          req;
    logic          req_valid, back_ready;
    logic          spr_en, spr_we, vid_en, vid_we;
    logic [7:0]    spr_addr, spr_wdata, spr_rdata, vid_wdata, vid_rdata;
    logic [AW-1:0] vid_addr;
    logic [7:0]    rd;
    logic          nmi, vbl;
    logic [8:0]    line, dot;

    // front stage owns raster position and cpu-visible address registers
    vppu_front #(.VIDEO_MEM_DEPTH(VIDEO_MEM_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_act(t_action'(i_s_tuser)), .i_addr(i_s_tdata[7:0]), .i_wdata(i_s_tdata[15:8]),
        .i_next_ready(back_ready), .o_valid(req_valid), .o_req(req),
        .o_spr_en(spr_en), .o_spr_we(spr_we), .o_spr_addr(spr_addr),
        .o_spr_wdata(spr_wdata),
        .o_vid_en(vid_en), .o_vid_we(vid_we), .o_vid_addr(vid_addr),
        .o_vid_wdata(vid_wdata)
    );

    // sprite attribute memory, 4 bytes per sprite
    vppu_ram #(.W(8), .D(SpriteMemDepth)) u_spr_ram (
        .i_clk(i_clk), .i_en(spr_en), .i_we(spr_we), .i_addr(spr_addr),
        .i_wdata(spr_wdata), .o_rdata(spr_rdata)
    );

    // video memory reached through the data port
    vppu_ram #(.W(8), .D(VIDEO_MEM_DEPTH)) u_vid_ram (
        .i_clk(i_clk), .i_en(vid_en), .i_we(vid_we), .i_addr(vid_addr),
        .i_wdata(vid_wdata), .o_rdata(vid_rdata)
    );

    // status stage consumes the registered ram read data of the request, held while it stalls
    vppu_back #(.SPRITES_PER_LINE(SPRITES_PER_LINE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(req_valid), .o_ready(back_ready), .i_req(req),
        .i_spr_rdata(spr_rdata), .i_vid_rdata(vid_rdata),
        .o_valid(o_m_tvalid), .i_out_ready(i_m_tready),
        .o_read_data(rd), .o_nmi(nmi), .o_line(line), .o_dot(dot), .o_vblank(vbl)
    );

    assign o_m_tdata = {4'd0, vbl, dot, line, nmi, rd};
endmodule
`default_nettype wire

// File: hw/rtl/vppu_ram.sv
// generic single-port ram with registered read
`default_nettype none
module vppu_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_addr,
    input  wire logic [W-1:0]         i_wdata,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: hw/rtl/vppu_front.sv
// front stage: raster counters, cpu-side registers and memory requests
`default_nettype none
module vppu_front #(
    parameter int VIDEO_MEM_DEPTH = vppu_pkg::VideoMemDepthDef
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire vppu_pkg::t_action                  i_act,
    input  wire logic [7:0]                         i_addr,
    input  wire logic [7:0]                         i_wdata,
    input  wire logic                               i_next_ready,
    output logic                                    o_valid,
    output vppu_pkg::t_req                          o_req,
    output logic                                    o_spr_en,
    output logic                                    o_spr_we,
    output logic [7:0]                              o_spr_addr,
    output logic [7:0]                              o_spr_wdata,
    output logic                                    o_vid_en,
    output logic                                    o_vid_we,
    output logic [$clog2(VIDEO_MEM_DEPTH)-1:0]      o_vid_addr,
    output logic [7:0]                              o_vid_wdata
);
    import vppu_pkg::*;
    localparam int AW = $clog2(VIDEO_MEM_DEPTH);

    logic [8:0]  r_line, n_line, r_dot, n_dot;
    logic        r_odd, n_odd;
    logic [7:0]  r_ctrl, n_ctrl, r_mask, n_mask, r_spaddr, n_spaddr;
    logic        r_toggle, n_toggle;
    logic [15:0] r_vaddr, n_vaddr, r_taddr, n_taddr;
    logic [2:0]  r_finex, n_finex;
    logic [1:0]  r_ph, n_ph;
    logic [5:0]  r_idx, n_idx;
    logic        r_valid;
    t_req        r_req, n_req;
    logic        r_clearing;
    logic [AW:0] r_clr_cnt;
    logic        accept, adv;
    logic [9:0]  dot_inc, line_inc;
    logic        render_on;
    logic [15:0] vstep;
    logic        spr_en, spr_we, vid_en, vid_we;
    logic [7:0]  spr_addr;

    assign adv     = r_valid && i_next_ready;
    assign o_ready = !r_clearing && (!r_valid || adv);
    assign accept  = i_valid && o_ready;
    assign render_on = (r_mask[4] || r_mask[3]);
    assign vstep   = r_vaddr + (r_ctrl[2] ? 16'd32 : 16'd1);

    always_comb begin
        n_line = r_line; n_dot = r_dot; n_odd = r_odd;
        n_ctrl = r_ctrl; n_mask = r_mask; n_spaddr = r_spaddr;
        n_toggle = r_toggle; n_vaddr = r_vaddr; n_taddr = r_taddr;
        n_finex = r_finex; n_ph = r_ph; n_idx = r_idx;
        spr_en = 1'b0; spr_we = 1'b0; spr_addr = r_spaddr;
        vid_en = 1'b0; vid_we = 1'b0;
        dot_inc = 10'd0; line_inc = 10'd0;
        n_req = '0;
        n_req.act   = i_act;
        n_req.rg    = i_addr[2:0];
        n_req.wdata = i_wdata;
        n_req.ln    = r_line[7:0];
        unique case (i_act)
            ACT_TICK: begin
                n_req.vbl_clr = (r_line == LinePreRender) && (r_dot == 9'd1);
                n_req.vbl_set = (r_line == LineVblank) && (r_dot == 9'd1);
                if (r_line < LineVisEnd) begin
                    n_req.cnt_clr = (r_dot == 9'd1);
                    if (r_dot == DotEvalFirst) begin
                        n_req.eval = 1'b1;
                        spr_en = 1'b1;
                        spr_addr = 8'd0;
                        n_ph = 2'd1;
                        n_idx = 6'd1;
                    end else if (r_dot > DotEvalFirst && r_dot <= DotEvalLast) begin
                        if (r_ph == 2'd0) begin
                            n_req.eval = 1'b1;
                            spr_en = 1'b1;
                            spr_addr = {r_idx, 2'b00};
                            n_idx = r_idx + 6'd1;
                        end
                        n_ph = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                    end
                    // coarse x increment at the end of each 8-dot fetch group
                    if (render_on && r_dot[2:0] == 3'd0) begin
                        if (r_vaddr[4:0] == 5'd31) begin
                            n_vaddr = {r_vaddr[15:5], 5'd0} ^ 16'h0400;
                        end else begin
                            n_vaddr = r_vaddr + 16'd1;
                        end
                    end
                end
                dot_inc = {1'b0, r_dot} + 10'd1;
                line_inc = {1'b0, r_line};
                if (dot_inc >= DotsPerLine) begin
                    dot_inc = 10'd0;
                    line_inc = {1'b0, r_line} + 10'd1;
                    if (line_inc >= LinesPerFrame) begin
                        line_inc = 10'd0;
                        n_odd = !r_odd;
                    end
                end
                // odd frames skip the first dot while rendering
                if (line_inc == 10'd0 && dot_inc == 10'd0 && n_odd && render_on) begin
                    dot_inc = 10'd1;
                end
                n_line = line_inc[8:0];
                n_dot  = dot_inc[8:0];
            end
            ACT_READ: begin
                unique case (i_addr[2:0])
                    REG_STATUS: n_toggle = 1'b0;
                    REG_SPDATA: spr_en = 1'b1;
                    REG_DATA: begin
                        vid_en = 1'b1;
                        n_vaddr = vstep;
                    end
                    default: ;
                endcase
            end
            ACT_WRITE: begin
                unique case (i_addr[2:0])
                    REG_CTRL: begin
                        n_ctrl = i_wdata;
                        n_taddr = {r_taddr[15:12], i_wdata[1:0], r_taddr[9:0]};
                    end
                    REG_MASK:   n_mask = i_wdata;
                    REG_SPADDR: n_spaddr = i_wdata;
                    REG_SPDATA: begin
                        spr_en = 1'b1;
                        spr_we = 1'b1;
                        n_spaddr = r_spaddr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_finex = i_wdata[2:0];
                            n_taddr = {r_taddr[15:5], i_wdata[7:3]};
                        end else begin
                            n_taddr = {r_taddr[15], i_wdata[2:0], r_taddr[11:10],
                                       i_wdata[7:3], r_taddr[4:0]};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_taddr = {2'b00, i_wdata[5:0], r_taddr[7:0]};
                        end else begin
                            n_taddr = {r_taddr[15:8], i_wdata};
                            n_vaddr = {r_taddr[15:8], i_wdata};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_DATA: begin
                        vid_en = 1'b1;
                        vid_we = 1'b1;
                        n_vaddr = vstep;
                    end
                    default: ;
                endcase
            end
            ACT_SPR: begin
                spr_en = 1'b1;
                spr_we = 1'b1;
                spr_addr = i_addr;
            end
            default: ;
        endcase
        n_req.ctrl_nmi = n_ctrl[7];
        n_req.line = n_line;
        n_req.dot  = n_dot;
    end

    // ram ports: clearing sweep after reset, else the accepted transaction
    always_comb begin
        if (r_clearing) begin
            o_spr_en = 1'b1; o_spr_we = 1'b1; o_spr_addr = r_clr_cnt[7:0];
            o_vid_en = 1'b1; o_vid_we = 1'b1; o_vid_addr = r_clr_cnt[AW-1:0];
            o_spr_wdata = 8'd0; o_vid_wdata = 8'd0;
        end else begin
            o_spr_en = accept && spr_en; o_spr_we = spr_we; o_spr_addr = spr_addr;
            o_vid_en = accept && vid_en; o_vid_we = vid_we;
            o_vid_addr = AW'(r_vaddr[10:0]);
            o_spr_wdata = i_wdata; o_vid_wdata = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= LinePreRender; r_dot <= 9'd0; r_odd <= 1'b0;
            r_ctrl <= 8'd0; r_mask <= 8'd0; r_spaddr <= 8'd0; r_toggle <= 1'b0;
            r_vaddr <= 16'd0; r_taddr <= 16'd0; r_finex <= 3'd0;
            r_ph <= 2'd0; r_idx <= 6'd0; r_valid <= 1'b0;
            r_clearing <= 1'b1; r_clr_cnt <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (AW+1)'(VIDEO_MEM_DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (accept) begin
                r_line <= n_line; r_dot <= n_dot; r_odd <= n_odd;
                r_ctrl <= n_ctrl; r_mask <= n_mask; r_spaddr <= n_spaddr;
                r_toggle <= n_toggle; r_vaddr <= n_vaddr; r_taddr <= n_taddr;
                r_finex <= n_finex; r_ph <= n_ph; r_idx <= n_idx;
                r_valid <= 1'b1;
            end else if (adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= n_req;
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
endmodule
`default_nettype wire

// File: hw/rtl/vppu_back.sv
// status stage: memory read data, status flags, bus latch and output register
`default_nettype none
module vppu_back #(
    parameter int SPRITES_PER_LINE = vppu_pkg::SpritesPerLineDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire vppu_pkg::t_req i_req,
    input  wire logic [7:0]     i_spr_rdata,
    input  wire logic [7:0]     i_vid_rdata,
    output logic                o_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_read_data,
    output logic                o_nmi,
    output logic [8:0]          o_line,
    output logic [8:0]          o_dot,
    output logic                o_vblank
);
    import vppu_pkg::*;
    localparam int CW = $clog2(SPRITES_PER_LINE + 1);

    logic          r_vbl, n_vbl, r_ovf, n_ovf, r_nmi_prev, n_line_nmi;
    logic [7:0]    r_bus, n_bus, r_rbuf, n_rbuf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, take;
    logic [7:0]    r_rd;
    logic          r_nmi, r_ovb;
    logic [8:0]    r_oline, r_odot;
    logic          hit;

    assign o_ready = !r_valid || i_out_ready;
    assign take    = i_valid && o_ready;
    assign hit = ({1'b0, i_req.ln} >= {1'b0, i_spr_rdata}) &&
                 ({1'b0, i_req.ln} < ({1'b0, i_spr_rdata} + 9'd8));

    always_comb begin
        n_vbl = r_vbl; n_ovf = r_ovf; n_bus = r_bus; n_rbuf = r_rbuf; n_cnt = r_cnt;
        unique case (i_req.act)
            ACT_TICK: begin
                if (i_req.vbl_clr) begin
                    n_vbl = 1'b0;
                    n_ovf = 1'b0;
                end
                if (i_req.vbl_set) n_vbl = 1'b1;
                if (i_req.cnt_clr) n_cnt = '0;
                if (i_req.eval && hit) begin
                    if (r_cnt < CW'(SPRITES_PER_LINE)) n_cnt = r_cnt + 1'b1;
                    else n_ovf = 1'b1;
                end
            end
            ACT_READ: begin
                unique case (i_req.rg)
                    REG_STATUS: begin
                        n_bus = {r_vbl, 1'b0, r_ovf, r_bus[4:0]};
                        n_vbl = 1'b0;
                    end
                    REG_SPDATA: n_bus = i_spr_rdata;
                    REG_DATA: begin
                        n_bus  = r_rbuf;
                        n_rbuf = i_vid_rdata;
                    end
                    default: ;
                endcase
            end
            ACT_WRITE: n_bus = i_req.wdata;
            ACT_SPR: ;
            default: ;
        endcase
        n_line_nmi = i_req.ctrl_nmi && n_vbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbl <= 1'b0; r_ovf <= 1'b0; r_nmi_prev <= 1'b0;
            r_bus <= 8'd0; r_rbuf <= 8'd0; r_cnt <= '0; r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_vbl <= n_vbl; r_ovf <= n_ovf; r_nmi_prev <= n_line_nmi;
                r_bus <= n_bus; r_rbuf <= n_rbuf; r_cnt <= n_cnt;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd <= n_bus;
            r_nmi <= n_line_nmi && !r_nmi_prev;
            r_oline <= i_req.line;
            r_odot <= i_req.dot;
            r_ovb <= n_vbl;
        end
    end

    assign o_valid = r_valid;
    assign o_read_data = r_rd;
    assign o_nmi = r_nmi;
    assign o_line = r_oline;
    assign o_dot = r_odot;
    assign o_vblank = r_ovb;
endmodule
`default_nettype wire

// File: hw/rtl/vppu_checker.sv
// port-level checks for the video register and raster timing core
`default_nettype none
module vppu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);
    a_nmi_needs_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tdata[27])
        else $error("nmi without vblank");

    a_raster_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[17:9] <= 9'd261) && (o_m_tdata[26:18] <= 9'd340))
        else $error("raster position out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");
endmodule

bind video_ppu_registers_and_timing_core vppu_checker u_vppu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
`default_nettype wire

// File: test/tb.sv
// testbench for the video register and raster timing core
`timescale 1ns / 100ps
`default_nettype none

// scoreboard: predicts each result of the raster core and checks arrivals
class raster_scoreboard;
    logic [8:0]  line_cnt;
    logic [8:0]  dot_cnt;
    logic        odd_frame;
    logic        vbl_occ;
    logic        nmi_prev;
    logic [7:0]  status;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
    logic [7:0]  spr_addr;
    logic        toggle;
    logic [15:0] vaddr;
    logic [15:0] taddr;
    logic [2:0]  fine_x;
    logic [7:0]  bus;
    logic [7:0]  rbuf;
    logic [7:0]  spr_mem [256];
    logic [7:0]  line_spr [32];
    logic [3:0]  line_spr_cnt;
    logic [7:0]  vmem [8192];
    logic [7:0]  bg_lat [4];
    logic [31:0] pending_results [$];
    int          errors;

    function new();
        line_cnt = 9'd261;
        dot_cnt = 0;
        odd_frame = 0;
        vbl_occ = 0;
        nmi_prev = 0;
        status = 0;
        ctrl = 0;
        mask = 0;
        spr_addr = 0;
        toggle = 0;
        vaddr = 0;
        taddr = 0;
        fine_x = 0;
        bus = 0;
        rbuf = 0;
        line_spr_cnt = 0;
        errors = 0;
        foreach (spr_mem[i]) spr_mem[i] = 0;
        foreach (line_spr[i]) line_spr[i] = 0;
        foreach (vmem[i]) vmem[i] = 0;
        foreach (bg_lat[i]) bg_lat[i] = 0;
    endfunction

    function void vaddr_step();
        vaddr = vaddr + (ctrl[2] ? 16'd32 : 16'd1);
    endfunction

    function void dot_tick();
        int unsigned ln;
        int unsigned dt;
        int unsigned s;
        int unsigned y;
        int unsigned base;
        int unsigned fy;
        ln = line_cnt;
        dt = dot_cnt;
        if (ln == 261 && dt == 1) begin
            vbl_occ = 0;
            status = status & 8'h1F;
        end
        if (ln == 241 && dt == 1) begin
            vbl_occ = 1;
            status = status | 8'h80;
        end
        if (ln < 240) begin
            if (dt == 1) line_spr_cnt = 0;
            if (dt >= 65 && dt <= 256 && ((dt - 65) % 3) == 0) begin
                s = (dt - 65) / 3;
                if (s < 64) begin
                    y = spr_mem[s*4];
                    if (ln >= y && ln < y + 8) begin
                        if (line_spr_cnt < 8) begin
                            for (int i = 0; i < 4; i++)
                                line_spr[line_spr_cnt*4+i] = spr_mem[s*4+i];
                            line_spr_cnt++;
                        end else begin
                            status = status | 8'h20;
                        end
                    end
                end
            end
            if (mask & 8'h18) begin
                base = ctrl[4] ? 32'h1000 : 0;
                fy = (vaddr >> 12) & 7;
                case (dt % 8)
                    1: bg_lat[0] = vmem[vaddr & 16'h07FF];
                    3: bg_lat[1] = vmem[(16'h03C0 | (vaddr & 16'h0C00) | ((vaddr >> 4) & 16'h38)
                                         | ((vaddr >> 2) & 16'h07)) % 8192];
                    5: bg_lat[2] = vmem[(base + bg_lat[0] * 16 + fy) % 8192];
                    7: bg_lat[3] = vmem[(base + bg_lat[0] * 16 + fy + 8) % 8192];
                    0: begin
                        if (vaddr[4:0] == 5'd31) vaddr = (vaddr & 16'hFFE0) ^ 16'h0400;
                        else vaddr = vaddr + 1;
                    end
                    default: ;
                endcase
            end
        end
        dot_cnt++;
        if (dot_cnt >= 341) begin
            dot_cnt = 0;
            line_cnt++;
            if (line_cnt >= 262) begin
                line_cnt = 0;
                odd_frame = ~odd_frame;
            end
        end
        if (line_cnt == 0 && dot_cnt == 0 && odd_frame && (mask & 8'h18)) dot_cnt = 1;
    endfunction

    function void reg_read(logic [2:0] r);
        logic [7:0] d;
        d = bus;
        case (r)
            vppu_pkg::REG_STATUS: begin
                d = (status & 8'hE0) | (bus & 8'h1F);
                vbl_occ = 0;
                status = status & 8'h7F;
                toggle = 0;
            end
            vppu_pkg::REG_SPDATA: d = spr_mem[spr_addr];
            vppu_pkg::REG_DATA: begin
                d = rbuf;
                rbuf = vmem[vaddr & 16'h07FF];
                vaddr_step();
            end
            default: ;
        endcase
        bus = d;
    endfunction

    function void reg_write(logic [2:0] r, logic [7:0] d);
        case (r)
            vppu_pkg::REG_CTRL: begin
                ctrl = d;
                taddr = (taddr & 16'hF3FF) | ({14'd0, d[1:0]} << 10);
            end
            vppu_pkg::REG_MASK: mask = d;
            vppu_pkg::REG_SPADDR: spr_addr = d;
            vppu_pkg::REG_SPDATA: begin
                spr_mem[spr_addr] = d;
                spr_addr = spr_addr + 1;
            end
            vppu_pkg::REG_SCROLL: begin
                if (!toggle) begin
                    fine_x = d[2:0];
                    taddr = (taddr & 16'hFFE0) | {11'd0, d[7:3]};
                    toggle = 1;
                end else begin
                    taddr = (taddr & 16'h8FFF) | ({13'd0, d[2:0]} << 12);
                    taddr = (taddr & 16'hFC1F) | ({8'd0, d & 8'hF8} << 2);
                    toggle = 0;
                end
            end
            vppu_pkg::REG_ADDR: begin
                if (!toggle) begin
                    taddr = (taddr & 16'h00FF) | ({10'd0, d[5:0]} << 8);
                    toggle = 1;
                end else begin
                    taddr = (taddr & 16'hFF00) | {8'd0, d};
                    vaddr = taddr;
                    toggle = 0;
                end
            end
            vppu_pkg::REG_DATA: begin
                vmem[vaddr & 16'h07FF] = d;
                vaddr_step();
            end
            default: ;
        endcase
        bus = d;
    endfunction

    // note an accepted input transaction and queue its expected result
    function void note_input(vppu_pkg::t_action act, logic [7:0] addr, logic [7:0] wd);
        logic nmi_line;
        logic nmi_req;
        case (act)
            vppu_pkg::ACT_TICK:  dot_tick();
            vppu_pkg::ACT_READ:  reg_read(addr[2:0]);
            vppu_pkg::ACT_WRITE: reg_write(addr[2:0], wd);
            default:             spr_mem[addr] = wd;
        endcase
        nmi_line = ctrl[7] & vbl_occ;
        nmi_req = ~nmi_prev & nmi_line;
        nmi_prev = nmi_line;
        pending_results.push_back({4'd0, status[7], dot_cnt, line_cnt, nmi_req, bus});
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endfunction

    // check a result transaction against the oldest expectation
    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (pending_results.size() == 0) begin
            report("unexpected result", got, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got[7:0] != want[7:0]) report("read_data", got[7:0], want[7:0]);
        if (got[8] != want[8]) report("nmi_request", got[8], want[8]);
        if (got[17:9] != want[17:9]) report("line_number", got[17:9], want[17:9]);
        if (got[26:18] != want[26:18]) report("dot_number", got[26:18], want[26:18]);
        if (got[27] != want[27]) report("in_vblank", got[27], want[27]);
    endfunction
endclass

module tb;
    import vppu_pkg::*;

    localparam int WatchdogLimit = 40000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = 0;   // address[7:0], write_data[15:8]
    logic [1:0]  i_s_tuser = 0;   // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [31:0] o_m_tdata;       // read_data, nmi_request, line, dot, in_vblank

    raster_scoreboard board = new();
    bit   no_idle = 0;           // long stretch without gaps on either side
    bit   stim_done = 0;
    int   quiet_cycles = 0;

    video_ppu_registers_and_timing_core dut (.*);

    always #6 i_clk = ~i_clk;

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                board.note_input(t_action'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[15:8]);
            if (o_m_tvalid && i_m_tready)
                board.check_result(o_m_tdata);
        end
    end

    // receiver stalls at random, ready changes on the falling edge
    always @(negedge i_clk)
        i_m_tready <= no_idle || ($urandom_range(99) >= 31);

    // watchdog on cycles with no transaction (covers the clearing sweep too)
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // send one input transaction, with a random gap before it unless no_idle is set
    task automatic send(t_action act, logic [7:0] addr, logic [7:0] wd);
        if (!no_idle) begin
            while ($urandom_range(99) < 31) begin
                i_s_tvalid <= 0;
                @(negedge i_clk);
            end
        end
        i_s_tvalid <= 1;
        i_s_tuser <= act;
        i_s_tdata <= {wd, addr};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic ticks(int n);
        for (int k = 0; k < n; k++) send(ACT_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // mostly ticks, with register accesses of realistic shapes mixed in
    task automatic random_item();
        int pick;
        logic [7:0] d;
        pick = $urandom_range(99);
        d = 8'($urandom);
        if (pick < 55) send(ACT_TICK, 8'($urandom), d);
        else if (pick < 70) send(ACT_READ, 8'($urandom), d);
        else if (pick < 85) send(ACT_WRITE, 8'($urandom), d);
        else if (pick < 90) send(ACT_SPR, 8'($urandom), d);
        else if (pick < 95) begin
            send(ACT_WRITE, 8'({5'($urandom), REG_ADDR}), d);
            send(ACT_WRITE, 8'({5'($urandom), REG_ADDR}), 8'($urandom));
        end else begin
            send(ACT_WRITE, 8'(REG_MASK), {3'($urandom), 2'b11, 3'($urandom)});
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: every register both ways, mirrors, extremes
        send(ACT_SPR, 8'd0, 8'd0);
        send(ACT_SPR, 8'd255, 8'hFF);
        send(ACT_WRITE, 8'(REG_SPADDR), 8'd255);
        send(ACT_READ, 8'(REG_SPDATA), 8'h00);
        send(ACT_WRITE, 8'(REG_SPDATA), 8'hA5);
        send(ACT_READ, 8'(REG_SPDATA), 8'h00);
        send(ACT_WRITE, 8'(REG_SCROLL), 8'hFF);
        send(ACT_WRITE, 8'(REG_SCROLL), 8'h5A);
        send(ACT_WRITE, 8'(REG_ADDR), 8'hFF);
        send(ACT_WRITE, 8'(REG_ADDR), 8'hFF);
        send(ACT_WRITE, 8'(REG_DATA), 8'h3C);
        send(ACT_WRITE, 8'(REG_CTRL), 8'h04);
        send(ACT_WRITE, 8'(REG_DATA), 8'hC3);
        send(ACT_READ, 8'(REG_DATA), 8'h00);
        send(ACT_READ, 8'hFF, 8'h00);
        send(ACT_WRITE, 8'(REG_STATUS), 8'h77);
        send(ACT_READ, 8'(REG_STATUS), 8'h00);
        send(ACT_READ, 8'(REG_MASK), 8'h00);
        send(ACT_READ, 8'(REG_CTRL), 8'h00);
        send(ACT_READ, 8'(REG_SPADDR), 8'h00);
        send(ACT_READ, 8'(REG_SCROLL), 8'h00);
        send(ACT_READ, 8'(REG_ADDR), 8'h00);
        send(ACT_WRITE, 8'h08 | 8'(REG_CTRL), 8'hFF);
        send(ACT_WRITE, 8'(REG_CTRL), 8'h00);
        send(ACT_WRITE, 8'(REG_MASK), 8'h18);

        // pause until everything is back
        drain();
        repeat (4) @(negedge i_clk);

        // random part, with a long no-idle stretch in the middle
        for (int n = 0; n < 650; n++) begin
            no_idle = (n >= 250 && n < 400);
            random_item();
        end
        no_idle = 0;

        // a few more dots on the new frame
        ticks(40);

        drain();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: video_ppu_registers_and_timing_core.f
hw/rtl/vppu_pkg.sv
hw/rtl/vppu_ram.sv
hw/rtl/vppu_front.sv
hw/rtl/vppu_back.sv
hw/rtl/video_ppu_registers_and_timing_core.sv
hw/rtl/vppu_checker.sv
test/tb.sv
